// ===== hdl/cia_pkg.sv =====
// Shared types and codes for the checked integer ALU.
package cia_pkg;

    localparam int DATA_W     = 64;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOD = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLR = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVF_FLAG  = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVF_FATAL = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIV_ZERO  = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_OP    = 3'd4;

    // register index as seen on paddr[APB_ADDR_W-1]
    localparam logic REG_SANDBOX = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } alu_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [STAT_W-1:0]        status;
        logic                     overflow_seen;
    } alu_out_t;

    typedef struct packed {
        logic start;
        logic div;
    } md_ctl_t;

endpackage

// ===== hdl/cia_muldiv.sv =====
// Bit-serial unsigned multiply / restoring divide on one shared adder.
module cia_muldiv #(
    parameter int W = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cia_pkg::md_ctl_t ctl,
    input  logic [W-1:0]     mag_a,
    input  logic [W-1:0]     mag_b,
    output logic             done,
    output logic [W-1:0]     hi,
    output logic [W-1:0]     lo
);
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg;
    logic [W-1:0]     hi_reg, lo_reg, mb_reg;
    logic [W-1:0]     hi_step, lo_step;
    logic [W:0]       shifted;
    logic [W+1:0]     add_x, add_y, sum;
    logic             add_cin;

    assign shifted = {hi_reg, lo_reg[W-1]};

    always_comb
    begin
        if (div_reg)
        begin
            add_x   = {1'b0, shifted};
            add_y   = ~{2'b00, mb_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = {2'b00, hi_reg};
            add_y   = lo_reg[0] ? {2'b00, mb_reg} : '0;
            add_cin = 1'b0;
        end
        sum = add_x + add_y + {{(W+1){1'b0}}, add_cin};

        if (div_reg)
        begin
            hi_step = sum[W+1] ? shifted[W-1:0] : sum[W-1:0];
            lo_step = {lo_reg[W-2:0], ~sum[W+1]};
        end
        else
        begin
            hi_step = sum[W:1];
            lo_step = {sum[0], lo_reg[W-1:1]};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            div_reg <= ctl.div;
            hi_reg  <= '0;
            lo_reg  <= mag_a;
            mb_reg  <= mag_b;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_step;
            lo_reg <= lo_step;
        end
    end

    assign done = done_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

// ===== hdl/checked_integer_alu_top.sv =====
// Checked integer ALU top level: APB register, handshake channels and sequencer.
//
// Usage:
//   in_valid/in_ready carries one transaction: command, operand_a, operand_b.
//   Only the low WORD_BITS bits of each operand count (sign-extended).
//   out_valid/out_ready carries one transaction per input: result, status and
//   the sticky overflow flag after that command.
//   Add, subtract, clear and invalid commands: accept, final step, then output register.
//   Multiply, divide, modulo: the bit-serial unit runs after accept, then the
//   final step loads the output register.
//   in_ready is high only while the sequencer is idle, so one command is in
//   flight at a time. A new command is taken while the previous result still
//   sits in the output register.
//   When the receiver stalls, the result holds in the output register and the
//   next command waits in its final step until the register frees up.
//   APB register 0 (address 0): sandboxed_mode. pready is always high.
//   Reset clears sandboxed_mode, the sticky flag and all valid state.
module checked_integer_alu_top #(
    parameter int WORD_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cia_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cia_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cia_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cia_pkg::alu_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cia_pkg::alu_out_t                out_data
);
    import cia_pkg::*;

    localparam int W = WORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               sandbox_reg;
    logic               flag_reg, flag_next;
    logic               out_valid_reg;
    alu_out_t           out_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [W-1:0]       a_reg, b_reg;

    logic               accept, load, cfg_wr, is_md;
    logic [W-1:0]       a_in, b_in, mag_a_in, mag_b_in;
    md_ctl_t            md_ctl;
    logic               md_done;
    logic [W-1:0]       md_hi, md_lo;

    logic [W-1:0]       fin_x, fin_y, mag_sel, r_sel;
    logic               fin_cin, neg_ab, neg_res, b_zero, ovf;
    logic [W:0]         fin_sum;
    logic [STAT_W-1:0]  st_sel;
    logic signed [W-1:0] r_signed;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_SANDBOX) ? APB_DATA_W'(sandbox_reg) : '0;

    // input side
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign a_in     = in_data.operand_a[W-1:0];
    assign b_in     = in_data.operand_b[W-1:0];
    assign mag_a_in = a_in[W-1] ? (~a_in + W'(1)) : a_in;
    assign mag_b_in = b_in[W-1] ? (~b_in + W'(1)) : b_in;
    assign is_md    = (in_data.command == CMD_MUL) || (in_data.command == CMD_DIV)
                   || (in_data.command == CMD_MOD);
    assign md_ctl.start = accept && is_md;
    assign md_ctl.div   = (in_data.command != CMD_MUL);

    cia_muldiv #(.W(W)) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (md_ctl),
        .mag_a (mag_a_in),
        .mag_b (mag_b_in),
        .done  (md_done),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    // final step: one adder for add/sub or sign restore
    assign neg_ab = a_reg[W-1] ^ b_reg[W-1];
    assign b_zero = (b_reg == '0);

    always_comb
    begin
        fin_x   = '0;
        fin_y   = ~md_lo;
        fin_cin = 1'b1;
        mag_sel = md_lo;
        neg_res = neg_ab;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                fin_x   = a_reg;
                fin_y   = b_reg;
                fin_cin = 1'b0;
            end
            CMD_SUB:
            begin
                fin_x = a_reg;
                fin_y = ~b_reg;
            end
            CMD_MOD:
            begin
                fin_y   = ~md_hi;
                mag_sel = md_hi;
                neg_res = a_reg[W-1];
            end
            default:
            begin
                fin_y = ~md_lo;
            end
        endcase
        fin_sum = {fin_x[W-1], fin_x} + {fin_y[W-1], fin_y} + {{W{1'b0}}, fin_cin};
    end

    always_comb
    begin
        ovf       = 1'b0;
        st_sel    = ST_OK;
        flag_next = flag_reg;
        r_sel     = '0;
        unique case (cmd_reg)
            CMD_ADD, CMD_SUB:
            begin
                ovf   = fin_sum[W] ^ fin_sum[W-1];
                r_sel = fin_sum[W-1:0];
            end
            CMD_MUL:
            begin
                ovf   = (|md_hi) || (neg_ab ? (md_lo[W-1] && (|md_lo[W-2:0])) : md_lo[W-1]);
                r_sel = neg_res ? fin_sum[W-1:0] : mag_sel;
            end
            CMD_DIV:
            begin
                if (b_zero)
                begin
                    st_sel = ST_DIV_ZERO;
                end
                else
                begin
                    ovf   = !neg_ab && md_lo[W-1];
                    r_sel = neg_res ? fin_sum[W-1:0] : mag_sel;
                end
            end
            CMD_MOD:
            begin
                if (b_zero)
                begin
                    st_sel = ST_DIV_ZERO;
                end
                else
                begin
                    r_sel = neg_res ? fin_sum[W-1:0] : mag_sel;
                end
            end
            CMD_CLR:
            begin
                flag_next = 1'b0;
                r_sel     = W'(1);
            end
            default:
            begin
                st_sel = ST_BAD_OP;
            end
        endcase
        if (ovf)
        begin
            r_sel = '0;
            if (sandbox_reg)
            begin
                flag_next = 1'b1;
                st_sel    = ST_OVF_FLAG;
            end
            else
            begin
                st_sel = ST_OVF_FATAL;
            end
        end
    end

    assign r_signed = r_sel;
    assign load     = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_md ? S_CALC : S_FIN;
                end
            end
            S_CALC:
            begin
                if (md_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sandbox_reg   <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && (paddr[APB_ADDR_W-1] == REG_SANDBOX))
            begin
                sandbox_reg <= pwdata[0];
            end
            if (load)
            begin
                flag_reg      <= flag_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_data.command;
            a_reg   <= a_in;
            b_reg   <= b_in;
        end
        if (load)
        begin
            out_reg.result        <= DATA_W'(r_signed);
            out_reg.status        <= st_sel;
            out_reg.overflow_seen <= flag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("in_ready high right after a transaction");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == S_CALC))
        else $error("mul/div unit finished outside CALC");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != ST_OK)) |-> (out_data.result == '0))
        else $error("nonzero result with error status");

    a_flagged_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_OVF_FLAG)) |-> out_data.overflow_seen)
        else $error("flagged overflow without sticky flag");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the checked integer ALU: random and directed commands, APB mode writes.
`timescale 1ns / 1ps

module tb_top;
    import cia_pkg::*;

    localparam logic [CMD_W-1:0]      CMD_RSVD_A   = 3'd6;
    localparam logic [CMD_W-1:0]      CMD_RSVD_B   = 3'd7;
    localparam logic [APB_ADDR_W-1:0] SANDBOX_ADDR = {REG_SANDBOX, 2'b00};
    localparam logic [DATA_W-1:0]     OP_MIN       = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0]     OP_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0]     OP_NEG1      = '1;
    localparam int                    RAND_PHASE   = 460;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    alu_in_t               in_data  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    alu_out_t              out_data;

    alu_in_t  cmd_backlog[$];
    alu_out_t pending_outcomes[$];
    logic     sandbox_on = 1'b0;
    logic     sticky_ovf = 1'b0;
    int       errors     = 0;
    int       in_gap     = 0;
    int       in_quiet   = 0;
    int       out_hold   = 0;
    int       out_quiet  = 0;

    checked_integer_alu_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #5 clk = ~clk;

    function automatic alu_out_t eval_checked_op(alu_in_t t);
        alu_out_t          res;
        logic [DATA_W:0]   wide;
        logic signed [127:0] prod;
        longint            sa;
        longint            sb;
        logic              ovf;
        res    = '0;
        ovf    = 1'b0;
        sa     = t.operand_a;
        sb     = t.operand_b;
        res.status = ST_OK;
        case (t.command)
            CMD_ADD:
            begin
                wide = {t.operand_a[DATA_W-1], t.operand_a} + {t.operand_b[DATA_W-1], t.operand_b};
                ovf  = wide[DATA_W] ^ wide[DATA_W-1];
                res.result = wide[DATA_W-1:0];
            end
            CMD_SUB:
            begin
                wide = {t.operand_a[DATA_W-1], t.operand_a} - {t.operand_b[DATA_W-1], t.operand_b};
                ovf  = wide[DATA_W] ^ wide[DATA_W-1];
                res.result = wide[DATA_W-1:0];
            end
            CMD_MUL:
            begin
                prod = $signed({{64{t.operand_a[DATA_W-1]}}, t.operand_a})
                     * $signed({{64{t.operand_b[DATA_W-1]}}, t.operand_b});
                ovf  = (prod[127:63] != '0) && (prod[127:63] != '1);
                res.result = prod[DATA_W-1:0];
            end
            CMD_DIV:
            begin
                if (t.operand_b == '0)
                    res.status = ST_DIV_ZERO;
                else if (t.operand_a == OP_MIN && t.operand_b == OP_NEG1)
                    ovf = 1'b1;
                else
                    res.result = sa / sb;
            end
            CMD_MOD:
            begin
                if (t.operand_b == '0)
                    res.status = ST_DIV_ZERO;
                else if (t.operand_b != OP_NEG1)
                    res.result = sa % sb;
            end
            CMD_CLR:
            begin
                sticky_ovf = 1'b0;
                res.result = 1;
            end
            default:
                res.status = ST_BAD_OP;
        endcase
        if (ovf)
        begin
            res.result = '0;
            if (sandbox_on)
            begin
                sticky_ovf = 1'b1;
                res.status = ST_OVF_FLAG;
            end
            else
            begin
                res.status = ST_OVF_FATAL;
            end
        end
        res.overflow_seen = sticky_ovf;
        return res;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 90);
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1: ;
            2, 3: v = v >> $urandom_range(1, 63);
            4:
            begin
                v = $urandom_range(0, 40);
                v = v - 20;
            end
            5:
            begin
                case ($urandom_range(0, 6))
                    0: v = OP_MIN;
                    1: v = OP_MAX;
                    2: v = '0;
                    3: v = OP_NEG1;
                    4: v = 1;
                    5: v = OP_MIN + 1;
                    default: v = OP_MAX - 1;
                endcase
            end
            6:
            begin
                v = 64'd1 << $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    v = v - 1;
            end
            default: v = v >> $urandom_range(28, 60);
        endcase
        if ($urandom_range(0, 3) == 0)
            v = -v;
        return v;
    endfunction

    function automatic alu_in_t random_cmd();
        alu_in_t it;
        int      r;
        r = $urandom_range(0, 99);
        if (r < 18)
            it.command = CMD_ADD;
        else if (r < 36)
            it.command = CMD_SUB;
        else if (r < 58)
            it.command = CMD_MUL;
        else if (r < 76)
            it.command = CMD_DIV;
        else if (r < 92)
            it.command = CMD_MOD;
        else if (r < 96)
            it.command = CMD_CLR;
        else
            it.command = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
        it.operand_a = pick_operand();
        it.operand_b = pick_operand();
        if (it.command == CMD_DIV || it.command == CMD_MOD)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                it.operand_b = '0;
            else if (r < 7)
            begin
                it.operand_a = OP_MIN;
                it.operand_b = OP_NEG1;
            end
        end
        return it;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b);
        alu_in_t it;
        it.command   = c;
        it.operand_a = a;
        it.operand_b = b;
        cmd_backlog.push_back(it);
    endtask

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // setup + access write, then setup + access readback
    task automatic set_sandbox(input logic mode);
        logic [APB_DATA_W-1:0] wval;
        wval    = $urandom;
        wval[0] = mode;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SANDBOX_ADDR;
        pwdata  <= wval;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sandbox_on = mode;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== mode)
            flag_mismatch($sformatf("sandboxed_mode readback: expected %0b, got %0b",
                                    mode, prdata[0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || in_valid || pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_outcomes.push_back(eval_checked_op(in_data));
            if (!(in_valid && !in_ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    in_data  <= cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (in_quiet > 0)
                    begin
                        in_quiet--;
                        in_gap = 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 24) == 0)
                            in_quiet = $urandom_range(20, 60);
                        in_gap = draw_gap();
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        alu_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected transaction: result=%0d status=%0d ovf=%0b",
                                            out_data.result, out_data.status,
                                            out_data.overflow_seen));
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (out_data.result !== want.result || out_data.status !== want.status
                        || out_data.overflow_seen !== want.overflow_seen)
                        flag_mismatch($sformatf({"mismatch: expected result=%0d status=%0d ",
                                                 "ovf=%0b, got result=%0d status=%0d ovf=%0b"},
                                                want.result, want.status, want.overflow_seen,
                                                out_data.result, out_data.status,
                                                out_data.overflow_seen));
                end
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_quiet > 0)
                    out_quiet--;
                else if ($urandom_range(0, 99) == 0)
                    out_quiet = $urandom_range(100, 400);
                else if ($urandom_range(0, 3) == 0)
                    out_hold = draw_gap();
            end
        end
    end

    initial
    begin
        logic mode;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_sandbox(1'b1);
        queue_cmd(CMD_ADD, OP_MAX, 1);
        queue_cmd(CMD_ADD, OP_MIN, OP_NEG1);
        queue_cmd(CMD_ADD, OP_MAX, OP_MIN);
        queue_cmd(CMD_ADD, OP_NEG1, OP_NEG1);
        queue_cmd(CMD_CLR, OP_MAX, OP_MAX);
        queue_cmd(CMD_SUB, OP_MIN, 1);
        queue_cmd(CMD_SUB, 0, OP_MIN);
        queue_cmd(CMD_SUB, OP_MAX, OP_NEG1);
        queue_cmd(CMD_SUB, OP_MIN, OP_MIN);
        queue_cmd(CMD_MUL, OP_MAX, 2);
        queue_cmd(CMD_MUL, OP_MIN, OP_NEG1);
        queue_cmd(CMD_MUL, OP_MIN, 1);
        queue_cmd(CMD_MUL, -(64'd1 << 32), 64'd1 << 31);
        queue_cmd(CMD_MUL, 64'd1 << 32, 64'd1 << 31);
        queue_cmd(CMD_MUL, 0, OP_MIN);
        queue_cmd(CMD_DIV, 5, 0);
        queue_cmd(CMD_MOD, OP_MIN, 0);
        queue_cmd(CMD_DIV, OP_MIN, OP_NEG1);
        queue_cmd(CMD_MOD, OP_MIN, OP_NEG1);
        queue_cmd(CMD_DIV, -64'd7, 2);
        queue_cmd(CMD_MOD, -64'd7, 2);
        queue_cmd(CMD_MOD, 7, -64'd2);
        queue_cmd(CMD_DIV, OP_MAX, OP_MIN);
        queue_cmd(CMD_RSVD_A, OP_NEG1, OP_NEG1);
        queue_cmd(CMD_RSVD_B, 0, 0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            mode = ph[0];
            set_sandbox(mode);
            for (int n = 0; n < RAND_PHASE; n++)
                cmd_backlog.push_back(random_cmd());
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cia_pkg.sv
hdl/cia_muldiv.sv
hdl/checked_integer_alu_top.sv
sim/tb_top.sv
